[sv/opr_pkg.sv]
// shared types, constants and helpers of the playout reorder buffer
`timescale 1ns / 1ps
package opr_pkg;

    localparam int RING_SLOTS = 16;
    localparam int SLOT_W     = $clog2(RING_SLOTS);
    localparam int STEP_W     = 32;
    localparam int OUT_SLOT_W = 4;
    localparam int LEAD_W     = 8;
    localparam int DRAIN_W    = 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CATCHUP_LEAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_LEAD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DRAIN    = 2'd2;

    localparam logic ACT_BANK = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [LEAD_W-1:0]  CATCHUP_RESET = 8'd4;
    localparam logic [LEAD_W-1:0]  SKIP_RESET    = 8'd6;
    localparam logic [DRAIN_W-1:0] DRAIN_RESET   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_LEAD,
        ST_CHECK,
        ST_SCAN,
        ST_SCAN_DONE,
        ST_FLUSH
    } opr_state_t;

    // controller to datapath
    typedef struct packed {
        logic bank;
        logic seed;
        logic emit;
        logic emit_scan;
        logic flush;
        logic scan_start;
        logic scan_step;
        logic rd_scan;
    } opr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic can_go;
        logic hit;
        logic skip_ok;
        logic behind2;
        logic scan_last;
        logic found;
        logic pend_valid;
        logic out_free;
    } opr_status_t;

    // ring slot of a step, masked to the output slot width
    function automatic logic [OUT_SLOT_W-1:0] slot_of(input logic [STEP_W-1:0] step);
        logic [STEP_W-1:0] masked;
        masked = step & STEP_W'(RING_SLOTS - 1);
        return masked[OUT_SLOT_W-1:0];
    endfunction

endpackage

[sv/opr_ctrl.sv]
// controller state machine of the playout reorder buffer
`timescale 1ns / 1ps
module opr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_action,
    output logic                s_ready,
    input  opr_pkg::opr_status_t sts,
    output opr_pkg::opr_cmd_t    cmd
);
    import opr_pkg::*;

    opr_state_t state_reg, state_next;
    logic [1:0] adv_reg, adv_next;
    logic       emit_ok;

    assign emit_ok = !sts.pend_valid || sts.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            adv_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            adv_reg   <= adv_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_action == ACT_TICK) state_next = ST_SEED;
            end
            ST_SEED: state_next = ST_LEAD;
            ST_LEAD: state_next = ST_CHECK;
            ST_CHECK: begin
                priority if (adv_reg == 2'd0 || !sts.can_go) state_next = ST_FLUSH;
                else if (sts.hit)                            state_next = ST_CHECK;
                else if (sts.skip_ok)                        state_next = ST_SCAN;
                else                                         state_next = ST_FLUSH;
            end
            ST_SCAN: begin
                if (sts.scan_last) state_next = ST_SCAN_DONE;
            end
            ST_SCAN_DONE: begin
                if (!sts.found || emit_ok) state_next = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (!sts.pend_valid || sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_ready  = 1'b0;
        adv_next = adv_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.bank = s_valid && s_action == ACT_BANK;
            end
            ST_SEED: cmd.seed = 1'b1;
            ST_LEAD: adv_next = sts.behind2 ? 2'd2 : 2'd1;
            ST_CHECK: begin
                if (adv_reg != 2'd0 && sts.can_go) begin
                    priority if (sts.hit) begin
                        if (emit_ok) begin
                            cmd.emit = 1'b1;
                            adv_next = adv_reg - 2'd1;
                        end
                    end else if (sts.skip_ok) begin
                        cmd.scan_start = 1'b1;
                    end else begin
                        cmd = '0;
                    end
                end
            end
            ST_SCAN: begin
                cmd.rd_scan   = 1'b1;
                cmd.scan_step = 1'b1;
            end
            ST_SCAN_DONE: begin
                if (sts.found && emit_ok) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_scan = 1'b1;
                end
            end
            ST_FLUSH: cmd.flush = sts.pend_valid && sts.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

[sv/opr_dp.sv]
// datapath of the playout reorder buffer: ring, cursor, search and result registers
`timescale 1ns / 1ps
module opr_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  opr_pkg::opr_cmd_t               cmd,
    output opr_pkg::opr_status_t            sts,
    input  logic [opr_pkg::STEP_W-1:0]      s_step_number,
    input  logic                            cfg_valid,
    input  logic [opr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [opr_pkg::LEAD_W-1:0]      cfg_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [opr_pkg::STEP_W-1:0]      m_adopted_step,
    output logic [opr_pkg::OUT_SLOT_W-1:0]  m_slot_index,
    output logic                            m_was_skip,
    output logic                            m_last_of_tick
);
    import opr_pkg::*;

    logic [STEP_W-1:0]     slot_step_reg [RING_SLOTS];
    logic [RING_SLOTS-1:0] slot_vld_reg;
    logic [STEP_W-1:0]     cursor_reg, highest_reg;
    logic [LEAD_W-1:0]     catchup_reg, skip_reg;
    logic [DRAIN_W-1:0]    drain_reg;

    logic [SLOT_W-1:0]     scan_idx_reg;
    logic [STEP_W-1:0]     best_reg;
    logic                  found_reg;

    logic                  pend_valid_reg;
    logic [STEP_W-1:0]     pend_step_reg;
    logic                  pend_skip_reg;

    logic                  out_valid_reg;
    logic [STEP_W-1:0]     out_step_reg;
    logic [OUT_SLOT_W-1:0] out_slot_reg;
    logic                  out_skip_reg;
    logic                  out_last_reg;

    logic [STEP_W-1:0]     nxt;
    logic [SLOT_W-1:0]     rd_addr;
    logic [STEP_W-1:0]     rd_data;
    logic [STEP_W:0]       catchup_sum, skip_sum;
    logic                  cand;
    logic [STEP_W-1:0]     new_step;
    logic                  out_free;
    logic                  bank_we;

    assign nxt      = cursor_reg + 32'd1;
    assign rd_addr  = cmd.rd_scan ? scan_idx_reg : nxt[SLOT_W-1:0];
    // an empty slot reads as step zero
    assign rd_data  = slot_vld_reg[rd_addr] ? slot_step_reg[rd_addr] : '0;
    assign catchup_sum = {1'b0, cursor_reg} + {{(STEP_W+1-LEAD_W){1'b0}}, catchup_reg};
    assign skip_sum    = {1'b0, cursor_reg} + {{(STEP_W+1-LEAD_W){1'b0}}, skip_reg};
    assign cand     = rd_data > cursor_reg && (!found_reg || rd_data < best_reg);
    assign new_step = cmd.emit_scan ? best_reg : nxt;
    assign out_free = !out_valid_reg || m_ready;
    assign bank_we  = cmd.bank && s_step_number != '0;

    assign sts.can_go     = cursor_reg < highest_reg;
    assign sts.hit        = rd_data == nxt;
    assign sts.skip_ok    = {1'b0, highest_reg} > skip_sum;
    assign sts.behind2    = ({1'b0, highest_reg} > catchup_sum) && drain_reg >= 2'd2;
    assign sts.scan_last  = scan_idx_reg == SLOT_W'(RING_SLOTS - 1);
    assign sts.found      = found_reg;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;

    // ring payload
    always_ff @(posedge aclk) begin
        if (bank_we) slot_step_reg[s_step_number[SLOT_W-1:0]] <= s_step_number;
    end

    // control state and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_vld_reg   <= '0;
            cursor_reg     <= '0;
            highest_reg    <= '0;
            catchup_reg    <= CATCHUP_RESET;
            skip_reg       <= SKIP_RESET;
            drain_reg      <= DRAIN_RESET;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_CATCHUP_LEAD: catchup_reg <= cfg_data;
                    CFG_SKIP_LEAD:    skip_reg    <= cfg_data;
                    CFG_MAX_DRAIN:    drain_reg   <= cfg_data[DRAIN_W-1:0];
                    default:          drain_reg   <= drain_reg;
                endcase
            end
            if (bank_we) begin
                slot_vld_reg[s_step_number[SLOT_W-1:0]] <= 1'b1;
                if (s_step_number > highest_reg) highest_reg <= s_step_number;
            end
            if (cmd.seed && cursor_reg == '0 && highest_reg != '0) begin
                cursor_reg <= highest_reg - 32'd1;
            end
            if (cmd.emit) cursor_reg <= new_step;
            if (cmd.scan_start) found_reg <= 1'b0;
            else if (cmd.scan_step && cand) found_reg <= 1'b1;

            if (cmd.emit) pend_valid_reg <= 1'b1;
            else if (cmd.flush) pend_valid_reg <= 1'b0;

            if ((cmd.emit && pend_valid_reg) || cmd.flush) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    // search and result payload
    always_ff @(posedge aclk) begin
        if (cmd.scan_start) scan_idx_reg <= '0;
        else if (cmd.scan_step) scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
        if (cmd.scan_step && cand) best_reg <= rd_data;
        if (cmd.emit) begin
            pend_step_reg <= new_step;
            pend_skip_reg <= cmd.emit_scan;
        end
        // pending result moves out; last only when the tick ends
        if ((cmd.emit && pend_valid_reg) || cmd.flush) begin
            out_step_reg <= pend_step_reg;
            out_slot_reg <= slot_of(pend_step_reg);
            out_skip_reg <= pend_skip_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_adopted_step = out_step_reg;
    assign m_slot_index   = out_slot_reg;
    assign m_was_skip     = out_skip_reg;
    assign m_last_of_tick = out_last_reg;

endmodule

[sv/ordered_playout_reorder_buffer_top.sv]
// top level of the ordered playout reorder buffer
// bank transfer: no result, next item accepted the following cycle
// tick transfer: input busy through seed, lead check, a check per in-order adoption, a ring scan
//   (one slot per cycle) when a skip is taken, and a flush; the last result loads on the return to idle
// a stalled result register holds the tick in place and keeps the input busy
// reset (aresetn low, synchronous): ring empty, cursor and highest mark zero, defaults
`timescale 1ns / 1ps
module ordered_playout_reorder_buffer_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input item channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_action,
    input  logic [opr_pkg::STEP_W-1:0]      s_step_number,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [opr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [opr_pkg::LEAD_W-1:0]      cfg_data,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [opr_pkg::STEP_W-1:0]      m_adopted_step,
    output logic [opr_pkg::OUT_SLOT_W-1:0]  m_slot_index,
    output logic                            m_was_skip,
    output logic                            m_last_of_tick
);
    import opr_pkg::*;

    opr_cmd_t    cmd;
    opr_status_t sts;

    // the user must send config writes only while idle; the block does not enforce it and always accepts
    assign cfg_ready = 1'b1;

    // sequencer: seed, lead check, adopt or skip, flush with last flag
    opr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // ring, cursor, min search and result register
    opr_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_step_number  (s_step_number),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_adopted_step (m_adopted_step),
        .m_slot_index   (m_slot_index),
        .m_was_skip     (m_was_skip),
        .m_last_of_tick (m_last_of_tick)
    );

endmodule

[sv/opr_chk.sv]
// port-level checker of the playout reorder buffer and its bind
`timescale 1ns / 1ps
module opr_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_action,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [opr_pkg::STEP_W-1:0]      m_adopted_step,
    input logic                            m_was_skip,
    input logic                            m_last_of_tick
);
    import opr_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_adopted_step))
        else $error("result changed while stalled");

    // step zero is never adopted
    a_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_adopted_step != '0)
        else $error("adopted step zero");

    // a skip always closes its tick
    a_skip_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_was_skip |-> m_last_of_tick)
        else $error("skip not last of tick");

    // a tick keeps the input side busy
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_action == ACT_TICK |=> !s_ready)
        else $error("input ready right after a tick");

    // a bank transfer creates no result
    a_bank_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_action == ACT_BANK && !m_valid |=> !m_valid)
        else $error("result after a bank transfer");

endmodule

bind ordered_playout_reorder_buffer_top opr_chk u_opr_chk (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_action       (s_action),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_adopted_step (m_adopted_step),
    .m_was_skip     (m_was_skip),
    .m_last_of_tick (m_last_of_tick)
);

[tb/sv/ordered_playout_reorder_buffer_top_test.sv]
// self-checking testbench of the playout reorder buffer: directed table, random streams, then the rest of the table
`timescale 1ns / 1ps
module ordered_playout_reorder_buffer_top_test;
    import opr_pkg::*;

    localparam int          SETTLE_CYCLES = 40;       // longest tick incl. the ring scan, padded
    localparam int          HOLD_CYCLES   = 300;      // long receiver hold-off
    localparam int unsigned RUN_LIMIT_NS  = 5_000_000;

    typedef struct packed {
        logic [STEP_W-1:0]     step;
        logic [OUT_SLOT_W-1:0] slot;
        logic                  skip;
        logic                  last;
    } adoption_t;

    typedef enum logic [1:0] {ROW_BANK, ROW_TICK, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [STEP_W-1:0]     val;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic                  typed;
        logic [1:0]            typed_n;
        adoption_t             typed_res;
    } script_row_t;

    localparam int OPENING_ROWS = 26;
    localparam int NUM_ROWS     = 29;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_action;
    logic [STEP_W-1:0]      s_step_number;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [LEAD_W-1:0]      cfg_data;
    logic                   m_valid;
    logic                   m_ready;
    logic [STEP_W-1:0]      m_adopted_step;
    logic [OUT_SLOT_W-1:0]  m_slot_index;
    logic                   m_was_skip;
    logic                   m_last_of_tick;

    // predicted block state
    logic [STEP_W-1:0]  ring_step [RING_SLOTS];
    logic [STEP_W-1:0]  pred_cursor;
    logic [STEP_W-1:0]  top_banked;
    logic [LEAD_W-1:0]  lead_catchup;
    logic [LEAD_W-1:0]  lead_skip;
    logic [DRAIN_W-1:0] drain_limit;

    adoption_t          tick_out [2];
    int                 tick_count;
    adoption_t          pending_adoptions [$];
    adoption_t          due;

    int                 mismatch_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 hold_asks;
    int                 hold_served;
    logic [STEP_W-1:0]  stream_head;

    // bank, tick and register rows; the first OPENING_ROWS run before the random part, the rest close the run
    script_row_t script [NUM_ROWS] = '{
        '{ROW_TICK, 32'd0,          CFG_CATCHUP_LEAD, 1'b1, 2'd0, '0},  // empty buffer
        '{ROW_BANK, 32'd0,          CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},  // step zero ignored
        '{ROW_TICK, 32'hFFFF_FFFF,  CFG_CATCHUP_LEAD, 1'b1, 2'd0, '0},
        '{ROW_BANK, 32'd5,          CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},
        '{ROW_TICK, 32'd0,          CFG_CATCHUP_LEAD, 1'b1, 2'd1,       // seeds the cursor
          '{32'd5, 4'd5, 1'b0, 1'b1}},
        '{ROW_BANK, 32'd20,         CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},
        '{ROW_BANK, 32'd4,          CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},  // stale, evicts 20
        '{ROW_TICK, 32'd0,          CFG_CATCHUP_LEAD, 1'b1, 2'd0, '0},  // skip finds nothing
        '{ROW_BANK, 32'd7,          CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},
        '{ROW_BANK, 32'd6,          CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},
        '{ROW_TICK, 32'd0,          CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},  // drains two
        '{ROW_BANK, 32'd9,          CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},
        '{ROW_BANK, 32'd10,         CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},
        '{ROW_TICK, 32'd0,          CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},  // skip lands on 9, next tick adopts 10
        '{ROW_TICK, 32'd0,          CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},
        '{ROW_BANK, 32'd21,         CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},
        '{ROW_TICK, 32'd0,          CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},  // skip lands on 21
        '{ROW_REG,  32'd0,          CFG_MAX_DRAIN,    1'b0, 2'd0, '0},  // drain zero acts as one
        '{ROW_REG,  32'd0,          CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},
        '{ROW_REG,  32'd255,        CFG_SKIP_LEAD,    1'b0, 2'd0, '0},
        '{ROW_BANK, 32'd22,         CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},
        '{ROW_BANK, 32'd23,         CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},
        '{ROW_BANK, 32'd24,         CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},
        '{ROW_TICK, 32'd0,          CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},
        '{ROW_REG,  32'd3,          CFG_MAX_DRAIN,    1'b0, 2'd0, '0},  // drain three acts as two
        '{ROW_TICK, 32'd0,          CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},
        '{ROW_BANK, 32'hFFFF_FFFF,  CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},  // largest step
        '{ROW_TICK, 32'd0,          CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0},
        '{ROW_TICK, 32'd0,          CFG_CATCHUP_LEAD, 1'b0, 2'd0, '0}
    };

    ordered_playout_reorder_buffer_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_step_number  (s_step_number),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_adopted_step (m_adopted_step),
        .m_slot_index   (m_slot_index),
        .m_was_skip     (m_was_skip),
        .m_last_of_tick (m_last_of_tick)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("ordered_playout_reorder_buffer_top_test: errors");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    // one bank or tick through the predictor; a tick leaves its adoptions in tick_out
    task automatic predict_item(input logic act, input logic [STEP_W-1:0] stp);
        logic [STEP_W-1:0]     nxt;
        logic [STEP_W-1:0]     best;
        logic [OUT_SLOT_W-1:0] sl;
        logic                  found;
        logic                  stop;
        int                    adv;
        tick_count = 0;
        if (act == ACT_BANK) begin
            if (stp != '0) begin
                ring_step[stp[OUT_SLOT_W-1:0]] = stp;
                if (stp > top_banked)
                    top_banked = stp;
            end
        end else begin
            if (pred_cursor == '0 && top_banked != '0)
                pred_cursor = top_banked - 1'b1;
            // lead compares are done one bit wider so cursor + lead never wraps
            if ({1'b0, top_banked} > {1'b0, pred_cursor} + {25'd0, lead_catchup})
                adv = (drain_limit >= 2'd2) ? 2 : 1;
            else
                adv = 1;
            stop = 1'b0;
            while (adv > 0 && pred_cursor < top_banked && !stop) begin
                nxt = pred_cursor + 1'b1;
                sl  = nxt[OUT_SLOT_W-1:0];
                adv--;
                if (ring_step[sl] == nxt) begin
                    tick_out[tick_count] = '{nxt, sl, 1'b0, 1'b0};
                    tick_count++;
                    pred_cursor = nxt;
                end else if ({1'b0, top_banked} > {1'b0, pred_cursor} + {25'd0, lead_skip}) begin
                    // jump to the oldest banked step beyond the cursor, if any
                    found = 1'b0;
                    best  = '0;
                    for (int i = 0; i < RING_SLOTS; i++) begin
                        if (ring_step[i] > pred_cursor && (!found || ring_step[i] < best)) begin
                            best  = ring_step[i];
                            found = 1'b1;
                        end
                    end
                    if (found) begin
                        tick_out[tick_count] = '{best, best[OUT_SLOT_W-1:0], 1'b1, 1'b0};
                        tick_count++;
                        pred_cursor = best;
                    end
                    stop = 1'b1;
                end else begin
                    stop = 1'b1;
                end
            end
            if (tick_count > 0)
                tick_out[tick_count-1].last = 1'b1;
            for (int k = 0; k < tick_count; k++)
                pending_adoptions.push_back(tick_out[k]);
        end
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input logic act, input logic [STEP_W-1:0] stp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_step_number <= stp;
        do @(posedge aclk); while (!s_ready);
        predict_item(act, stp);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_adoptions.size() != 0)
            @(negedge aclk);
    endtask

    // registers change only with the block idle; a tick with no result may still be scanning
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEAD_W-1:0] data);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_CATCHUP_LEAD: lead_catchup = data;
            CFG_SKIP_LEAD:    lead_skip    = data;
            CFG_MAX_DRAIN:    drain_limit  = data[DRAIN_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_leads(input logic [LEAD_W-1:0] catchup, input logic [LEAD_W-1:0] skip,
                             input logic [LEAD_W-1:0] drain);
        write_reg(CFG_CATCHUP_LEAD, catchup);
        write_reg(CFG_SKIP_LEAD, skip);
        write_reg(CFG_MAX_DRAIN, drain);
    endtask

    task automatic run_rows(input int first, input int last);
        for (int i = first; i <= last; i++) begin
            case (script[i].kind)
                ROW_REG:  write_reg(script[i].reg_idx, script[i].val[LEAD_W-1:0]);
                ROW_BANK: send_item(ACT_BANK, script[i].val);
                default:  send_item(ACT_TICK, script[i].val);
            endcase
            if (script[i].typed && (tick_count != int'(script[i].typed_n) ||
                    (tick_count == 1 && tick_out[0] != script[i].typed_res)))
                flag_mismatch($sformatf("row %0d: predicted tick differs from table", i));
        end
    endtask

    // mostly in-order steps with loss and swaps, ticks in between, some stale and zero noise
    task automatic feed_stream(input int n_items);
        int sent;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 45 || stream_head > 32'hFFFF_FFF0) begin
                send_item(ACT_TICK, $urandom());
                sent++;
            end else if (pick < 85) begin
                if ($urandom_range(0, 9) == 0) begin
                    stream_head++;                      // lost in transit
                end else if ($urandom_range(0, 6) == 0) begin
                    send_item(ACT_BANK, stream_head + 1'b1);
                    send_item(ACT_BANK, stream_head);
                    stream_head += 2;
                    sent += 2;
                end else begin
                    send_item(ACT_BANK, stream_head);
                    stream_head++;
                    sent++;
                end
            end else if (pick < 92) begin
                if (pred_cursor != '0)
                    send_item(ACT_BANK, $urandom_range(1, pred_cursor));  // late arrival
                else
                    send_item(ACT_TICK, $urandom());
                sent++;
            end else if (pick < 95) begin
                send_item(ACT_BANK, '0);                // ignored, not counted
            end else if (pick < 98) begin
                stream_head += $urandom_range(2, 40);
            end else begin
                stream_head += $urandom_range(1000, 1 << 20);
            end
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_asks != hold_served) begin
                hold_served++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_adoptions.size() == 0) begin
                flag_mismatch($sformatf("unexpected adoption of step %0d", m_adopted_step));
            end else begin
                due = pending_adoptions.pop_front();
                if (m_adopted_step !== due.step)
                    flag_mismatch($sformatf("adopted_step %0d, want %0d",
                                            m_adopted_step, due.step));
                if (m_slot_index !== due.slot)
                    flag_mismatch($sformatf("slot_index %0d, want %0d (step %0d)",
                                            m_slot_index, due.slot, due.step));
                if (m_was_skip !== due.skip)
                    flag_mismatch($sformatf("was_skip %0b, want %0b (step %0d)",
                                            m_was_skip, due.skip, due.step));
                if (m_last_of_tick !== due.last)
                    flag_mismatch($sformatf("last_of_tick %0b, want %0b (step %0d)",
                                            m_last_of_tick, due.last, due.step));
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_action       = ACT_BANK;
        s_step_number  = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_CATCHUP_LEAD;
        cfg_data       = '0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_asks      = 0;
        hold_served    = 0;
        for (int i = 0; i < RING_SLOTS; i++)
            ring_step[i] = '0;
        pred_cursor  = '0;
        top_banked   = '0;
        lead_catchup = CATCHUP_RESET;
        lead_skip    = SKIP_RESET;
        drain_limit  = DRAIN_RESET;
        tick_count   = 0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part starts on the reset settings
        run_rows(0, OPENING_ROWS - 1);
        stream_head = top_banked + 1'b1;

        set_leads(8'd4, 8'd6, 8'd2);
        feed_stream(80);

        set_leads(8'd0, 8'd0, 8'd1);
        send_idle_pct = 45;
        feed_stream(80);

        set_leads(8'd255, 8'd255, 8'd2);
        send_idle_pct  = 0;
        recv_stall_pct = 45;
        feed_stream(80);

        set_leads(8'd2, 8'd3, 8'd3);
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        feed_stream(80);

        // long receiver hold-off while the sender keeps offering: the block backs up
        set_leads(8'd1, 8'd10, 8'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_asks++;
        feed_stream(80);

        // sender pauses mid-phase until every adoption has come out
        set_leads(LEAD_W'($urandom_range(0, 12)), LEAD_W'($urandom_range(0, 20)),
                  LEAD_W'($urandom_range(0, 3)));
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        feed_stream(40);
        wait_drained();
        feed_stream(40);

        // top of the step range, so the upper step bits get exercised
        set_leads(8'd4, 8'd6, 8'd2);
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        stream_head = 32'hFFFF_F000 + $urandom_range(0, 255);
        feed_stream(80);

        run_rows(OPENING_ROWS, NUM_ROWS - 1);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatch_count == 0)
            $display("ordered_playout_reorder_buffer_top_test: clean");
        else
            $display("ordered_playout_reorder_buffer_top_test: errors");
        $finish;
    end

endmodule
